[design/fdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared constants, register indexes and the logistic occupation table of the
// Fermi-Dirac charge density core.
// ----------------------------------------------------------------------------
package fdc_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;

  // logistic table
  localparam int TBL_DEPTH = 256;
  localparam int TBL_IDX_W = $clog2(TBL_DEPTH);
  localparam int OCC_W     = FRAC_BITS + 1;
  localparam int TBL_HALF  = TBL_DEPTH / 2;
  // table step 16/depth in Q31
  localparam longint TBL_AQ = (longint'(16) << 31) / TBL_DEPTH;

  // multiplier operand widths
  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 35;

  // magnitude caps
  localparam longint unsigned CHAIN_LIM = longint'(1) << 62;
  localparam longint unsigned X_CAP     = longint'(1) << 40;

  // register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_Q    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_OVER_KT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_DENS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COND_DENS   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_DENS    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_OFFSET  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COND_OFFSET = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_OFFSET  = 4'd7;

  typedef logic [OCC_W-1:0] occ_table_t [TBL_DEPTH];

  // unsigned restoring division, shift and subtract
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // table of 1/(1+e^x) over x in [-8, 8), built from integer arithmetic
  function automatic occ_table_t build_occ_table();
    occ_table_t     tbl;
    longint         term;
    longint         sum;
    longint unsigned r;
    longint unsigned p;
    longint unsigned den;
    longint unsigned q31;
    longint unsigned neg_side;
    int             hi;
    int             lo;
    q31  = longint'(1) << 31;
    term = longint'(q31);
    sum  = longint'(q31);
    for (int k = 1; k <= 24; k++) begin
      term = longint'(udiv(longint'((term * TBL_AQ) >>> 31), 64'(k)));
      if (k[0]) sum = sum - term;
      else sum = sum + term;
    end
    r = longint'(sum);
    p = q31;
    for (int k = 0; k <= TBL_HALF; k++) begin
      den      = q31 + p;
      hi       = TBL_HALF + k;
      lo       = TBL_HALF - k;
      neg_side = udiv((q31 << FRAC_BITS) + (den >> 1), den);
      if (hi < TBL_DEPTH) begin
        if (k == 0) tbl[hi] = OCC_W'(neg_side);
        else tbl[hi] = OCC_W'(udiv((p << FRAC_BITS) + (den >> 1), den));
      end
      if (lo >= 0) tbl[lo] = OCC_W'(neg_side);
      p = (p * r + (q31 >> 1)) >> 31;
    end
    return tbl;
  endfunction

  localparam occ_table_t OCC_TABLE = build_occ_table();

endpackage

[design/fermi_dirac_charge_density_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fermi_dirac_charge_density_core
// Residual and Jacobian of the Fermi-Dirac charge density at one point.
// ----------------------------------------------------------------------------
// One point is taken in every cycle; busy stays low. Each result appears on
// result_valid_o for one cycle, and the receiver cannot stall it. It comes
// after the longest chain of dependent steps: input capture, the three-stage
// occupation lookup, then the f*(1-f) and density products, the derivative
// sum, the g, test and shape products and the output register, each product
// being a three-stage multiplier. The user must write registers through
// cfg_we_i only while no point is in flight; the core does not enforce this.
module fermi_dirac_charge_density_core
  import fdc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   potential_i,
  input  logic signed [31:0]   test_value_i,
  input  logic signed [31:0]   shape_value_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic                 result_valid_o,
  output logic signed [31:0]   residual_o,
  output logic signed [31:0]   jacobian_o,
  output logic                 saturated_o
);

  localparam int VLD_STAGES   = 21;
  localparam int TEST_STAGES  = 13;
  localparam int SHAPE_STAGES = 16;
  localparam int JQ_STAGES    = 4;
  localparam int RES_STAGES   = 6;

  // configuration registers
  logic signed [31:0] charge_q_q;
  logic        [30:0] qkt_q;
  logic        [30:0] na_q;
  logic        [30:0] nc_q;
  logic        [30:0] nv_q;
  logic signed [31:0] off_a_q;
  logic signed [31:0] off_c_q;
  logic signed [31:0] off_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charge_q_q <= 32'(ONE_Q);
      qkt_q      <= 31'(ONE_Q);
      na_q       <= 31'(ONE_Q);
      nc_q       <= 31'(ONE_Q);
      nv_q       <= 31'(ONE_Q);
      off_a_q    <= '0;
      off_c_q    <= '0;
      off_v_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CHARGE_Q:    charge_q_q <= $signed(cfg_data_i);
        REG_Q_OVER_KT:   qkt_q      <= cfg_data_i[30:0];
        REG_ACC_DENS:    na_q       <= cfg_data_i[30:0];
        REG_COND_DENS:   nc_q       <= cfg_data_i[30:0];
        REG_VAL_DENS:    nv_q       <= cfg_data_i[30:0];
        REG_ACC_OFFSET:  off_a_q    <= $signed(cfg_data_i);
        REG_COND_OFFSET: off_c_q    <= $signed(cfg_data_i);
        REG_VAL_OFFSET:  off_v_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits travelling with the beat
  logic [VLD_STAGES-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_STAGES-2:0], start & ~busy};
    end
  end

  // input capture and operand delay lines
  logic signed [31:0] pot_q;
  logic signed [31:0] test_q;
  logic signed [31:0] shape_q;
  logic signed [31:0] test_pipe_q  [TEST_STAGES];
  logic signed [31:0] shape_pipe_q [SHAPE_STAGES];

  always_ff @(posedge clk_i) begin
    pot_q           <= potential_i;
    test_q          <= test_value_i;
    shape_q         <= shape_value_i;
    test_pipe_q[0]  <= test_q;
    shape_pipe_q[0] <= shape_q;
    for (int i = 1; i < TEST_STAGES; i++) test_pipe_q[i] <= test_pipe_q[i-1];
    for (int i = 1; i < SHAPE_STAGES; i++) shape_pipe_q[i] <= shape_pipe_q[i-1];
  end

  // occupations of the three levels
  logic [OCC_W-1:0] fa;
  logic [OCC_W-1:0] fc;
  logic [OCC_W-1:0] fv;

  fdc_occupation u_occ_a (
    .clk_i(clk_i), .potential_i(pot_q), .offset_i(off_a_q), .q_over_kt_i(qkt_q),
    .occ_o(fa)
  );
  fdc_occupation u_occ_c (
    .clk_i(clk_i), .potential_i(pot_q), .offset_i(off_c_q), .q_over_kt_i(qkt_q),
    .occ_o(fc)
  );
  fdc_occupation u_occ_v (
    .clk_i(clk_i), .potential_i(pot_q), .offset_i(off_v_q), .q_over_kt_i(qkt_q),
    .occ_o(fv)
  );

  // occupation operands
  logic signed [MUL_B_W-1:0] fa_b, fc_b, fv_b;
  logic signed [MUL_B_W-1:0] fa_n, fc_n, fv_n;
  logic signed [MUL_A_W-1:0] na_a, nc_a, nv_a, q_a;

  always_comb begin
    fa_b = $signed(MUL_B_W'(fa));
    fc_b = $signed(MUL_B_W'(fc));
    fv_b = $signed(MUL_B_W'(fv));
    fa_n = MUL_B_W'(ONE_Q) - fa_b;
    fc_n = MUL_B_W'(ONE_Q) - fc_b;
    fv_n = MUL_B_W'(ONE_Q) - fv_b;
    na_a = $signed(MUL_A_W'(na_q));
    nc_a = $signed(MUL_A_W'(nc_q));
    nv_a = $signed(MUL_A_W'(nv_q));
    q_a  = MUL_A_W'(charge_q_q);
  end

  // first product level
  logic signed [MUL_A_W-1:0] u_v, u_c, u_a, p_a, p_c, p_v, jq;

  fdc_fxmul u_mul_uv (.clk_i(clk_i), .a_i(nv_a), .b_i(fv_n), .p_o(u_v));
  fdc_fxmul u_mul_uc (.clk_i(clk_i), .a_i(nc_a), .b_i(fc_b), .p_o(u_c));
  fdc_fxmul u_mul_ua (.clk_i(clk_i), .a_i(na_a), .b_i(fa_b), .p_o(u_a));
  fdc_fxmul u_mul_pa (.clk_i(clk_i), .a_i(MUL_A_W'(fa_b)), .b_i(fa_n), .p_o(p_a));
  fdc_fxmul u_mul_pc (.clk_i(clk_i), .a_i(MUL_A_W'(fc_b)), .b_i(fc_n), .p_o(p_c));
  fdc_fxmul u_mul_pv (.clk_i(clk_i), .a_i(MUL_A_W'(fv_b)), .b_i(fv_n), .p_o(p_v));
  fdc_fxmul u_mul_jq (
    .clk_i(clk_i), .a_i(q_a), .b_i($signed(MUL_B_W'(qkt_q))), .p_o(jq)
  );

  // net density sum
  logic signed [MUL_B_W-1:0] s_q;

  always_ff @(posedge clk_i) begin
    s_q <= u_v[MUL_B_W-1:0] - u_c[MUL_B_W-1:0] - u_a[MUL_B_W-1:0];
  end

  // charge density and derivative weights
  logic signed [MUL_A_W-1:0] rho, n_a, n_c, n_v;

  fdc_fxmul u_mul_rho (.clk_i(clk_i), .a_i(q_a), .b_i(s_q), .p_o(rho));
  fdc_fxmul u_mul_na (.clk_i(clk_i), .a_i(na_a), .b_i(p_a[MUL_B_W-1:0]), .p_o(n_a));
  fdc_fxmul u_mul_nc (.clk_i(clk_i), .a_i(nc_a), .b_i(p_c[MUL_B_W-1:0]), .p_o(n_c));
  fdc_fxmul u_mul_nv (.clk_i(clk_i), .a_i(nv_a), .b_i(p_v[MUL_B_W-1:0]), .p_o(n_v));

  // derivative sum and q*q/kT alignment
  logic signed [MUL_B_W-1:0] g_q;
  logic signed [MUL_A_W-1:0] jq_pipe_q [JQ_STAGES];

  always_ff @(posedge clk_i) begin
    g_q          <= n_a[MUL_B_W-1:0] + n_c[MUL_B_W-1:0] + n_v[MUL_B_W-1:0];
    jq_pipe_q[0] <= jq;
    for (int i = 1; i < JQ_STAGES; i++) jq_pipe_q[i] <= jq_pipe_q[i-1];
  end

  // test, shape operands at their stages
  logic signed [MUL_B_W-1:0] test_b10, test_b13, shape_b16;

  assign test_b10  = MUL_B_W'(test_pipe_q[9]);
  assign test_b13  = MUL_B_W'(test_pipe_q[12]);
  assign shape_b16 = MUL_B_W'(shape_pipe_q[15]);

  // residual and jacobian product chains
  logic signed [MUL_A_W-1:0] res, jac1, jac2, jac3;

  fdc_fxmul u_mul_res (.clk_i(clk_i), .a_i(rho), .b_i(test_b10), .p_o(res));
  fdc_fxmul u_mul_j1 (
    .clk_i(clk_i), .a_i(jq_pipe_q[JQ_STAGES-1]), .b_i(g_q), .p_o(jac1)
  );
  fdc_fxmul u_mul_j2 (.clk_i(clk_i), .a_i(jac1), .b_i(test_b13), .p_o(jac2));
  fdc_fxmul u_mul_j3 (.clk_i(clk_i), .a_i(jac2), .b_i(shape_b16), .p_o(jac3));

  // residual delay to meet the jacobian
  logic signed [MUL_A_W-1:0] res_pipe_q [RES_STAGES];

  always_ff @(posedge clk_i) begin
    res_pipe_q[0] <= res;
    for (int i = 1; i < RES_STAGES; i++) res_pipe_q[i] <= res_pipe_q[i-1];
  end

  // saturation to 32 bits
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic signed [MUL_A_W-1:0] res_v, jac_v;
  logic signed [31:0]        res_d, jac_d;
  logic                      sat_d;
  logic signed [31:0]        res_out_q, jac_out_q;
  logic                      sat_out_q;

  always_comb begin
    res_v = res_pipe_q[RES_STAGES-1];
    jac_v = -jac3;
    sat_d = 1'b0;
    if (res_v > S32_MAX) begin
      res_d = 32'(S32_MAX);
      sat_d = 1'b1;
    end else if (res_v < S32_MIN) begin
      res_d = 32'(S32_MIN);
      sat_d = 1'b1;
    end else begin
      res_d = res_v[31:0];
    end
    if (jac_v > S32_MAX) begin
      jac_d = 32'(S32_MAX);
      sat_d = 1'b1;
    end else if (jac_v < S32_MIN) begin
      jac_d = 32'(S32_MIN);
      sat_d = 1'b1;
    end else begin
      jac_d = jac_v[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_out_q <= res_d;
    jac_out_q <= jac_d;
    sat_out_q <= sat_d;
  end

  assign result_valid_o = vld_q[VLD_STAGES-1];
  assign residual_o     = res_out_q;
  assign jacobian_o     = jac_out_q;
  assign saturated_o    = sat_out_q;

endmodule

[design/fdc_fxmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_fxmul
// Three-stage signed fixed point multiply: magnitudes, two partial products,
// then sum, fraction shift, magnitude cap and sign.
// ----------------------------------------------------------------------------
module fdc_fxmul
  import fdc_pkg::*;
(
  input  logic                      clk_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_A_W-1:0] p_o
);

  localparam int PP_W  = 32 + MUL_B_W;
  localparam int SUM_W = PP_W + 33;
  localparam int M_W   = SUM_W - FRAC_BITS;

  logic [MUL_A_W-1:0] ua_q;
  logic [MUL_B_W-1:0] ub_q;
  logic               neg_q;
  logic [PP_W-1:0]    plo_q;
  logic [PP_W-1:0]    phi_q;
  logic               neg2_q;
  logic [SUM_W-1:0]   full;
  logic [M_W-1:0]     mag;
  logic [MUL_A_W-1:0] capped;
  logic signed [MUL_A_W-1:0] p_q;

  // operand magnitudes and result sign
  always_ff @(posedge clk_i) begin
    ua_q  <= a_i[MUL_A_W-1] ? MUL_A_W'(-a_i) : MUL_A_W'(a_i);
    ub_q  <= b_i[MUL_B_W-1] ? MUL_B_W'(-b_i) : MUL_B_W'(b_i);
    neg_q <= a_i[MUL_A_W-1] ^ b_i[MUL_B_W-1];
  end

  // partial products over the low and high halves of a
  always_ff @(posedge clk_i) begin
    plo_q  <= PP_W'(ua_q[31:0]) * PP_W'(ub_q);
    phi_q  <= PP_W'(ua_q[MUL_A_W-1:32]) * PP_W'(ub_q);
    neg2_q <= neg_q;
  end

  // recombine, drop fraction bits, cap
  always_comb begin
    full = (SUM_W'(phi_q) << 32) + SUM_W'(plo_q);
    mag  = full[SUM_W-1:FRAC_BITS];
    if (mag > M_W'(CHAIN_LIM)) capped = MUL_A_W'(CHAIN_LIM);
    else capped = mag[MUL_A_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    p_q <= neg2_q ? -$signed(capped) : $signed(capped);
  end

  assign p_o = p_q;

endmodule

[design/fdc_occupation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_occupation
// Three-stage Fermi-Dirac occupation: level offset minus potential, scaling
// by q/kT, then nearest-entry lookup in the logistic table.
// ----------------------------------------------------------------------------
module fdc_occupation
  import fdc_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [31:0] potential_i,
  input  logic signed [31:0] offset_i,
  input  logic        [30:0] q_over_kt_i,
  output logic [OCC_W-1:0]   occ_o
);

  localparam int SPAN_SH = FRAC_BITS + 4;
  localparam longint T_BIAS = (longint'(TBL_DEPTH / 2) << SPAN_SH)
                              + (longint'(1) << (SPAN_SH - 1));
  localparam longint DEPTH_L = longint'(TBL_DEPTH);

  logic signed [32:0] d;
  logic        [32:0] md_q;
  logic               neg_q;
  logic        [63:0] prod_q;
  logic               neg2_q;
  logic        [47:0] xm;
  logic        [40:0] xc;
  logic signed [63:0] x;
  logic signed [63:0] t;
  logic        [63:0] quo;
  logic [TBL_IDX_W-1:0] idx;
  logic [OCC_W-1:0]   occ_q;

  // difference and its magnitude
  assign d = 33'(offset_i) - 33'(potential_i);

  always_ff @(posedge clk_i) begin
    md_q  <= d[32] ? 33'(-d) : 33'(d);
    neg_q <= d[32];
  end

  // scale by q/kT
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(q_over_kt_i) * 64'(md_q);
    neg2_q <= neg_q;
  end

  // table index with rounding and clamping at both ends
  always_comb begin
    xm = prod_q[63:FRAC_BITS];
    if (xm > 48'(X_CAP)) xc = 41'(X_CAP);
    else xc = xm[40:0];
    x   = neg2_q ? -$signed(64'(xc)) : $signed(64'(xc));
    t   = x * DEPTH_L + T_BIAS;
    quo = 64'(t) >> SPAN_SH;
    if (t < 0) idx = '0;
    else if (quo > 64'(TBL_DEPTH - 1)) idx = TBL_IDX_W'(TBL_DEPTH - 1);
    else idx = quo[TBL_IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    occ_q <= OCC_TABLE[idx];
  end

  assign occ_o = occ_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Fermi-Dirac charge density core. A queue of
// commands (points, register writes and drain marks) feeds a clocked driver
// that mirrors the register file and predicts residual, Jacobian and the
// saturation flag of every point taken; a clocked monitor compares each
// result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import fdc_pkg::*;

  typedef enum logic [1:0] {CMD_POINT, CMD_WRITE, CMD_DRAIN} cmd_kind_e;

  typedef struct {
    cmd_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic signed [31:0]   pot;
    logic signed [31:0]   test;
    logic signed [31:0]   shape;
    int                   gap;
  } cmd_t;

  typedef struct {
    logic signed [31:0] residual;
    logic signed [31:0] jacobian;
    logic               sat;
  } density_t;

  localparam int PIPE_LAT = 20;
  localparam int SETTLE   = PIPE_LAT + 8;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [31:0]   potential_i = '0;
  logic signed [31:0]   test_value_i = '0;
  logic signed [31:0]   shape_value_i = '0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]          cfg_data_i = '0;
  logic                 result_valid_o;
  logic signed [31:0]   residual_o;
  logic signed [31:0]   jacobian_o;
  logic                 saturated_o;

  cmd_t     cmd_q[$];
  density_t density_q[$];
  longint   reg_mirror[8];
  longint   occ_lut[TBL_DEPTH];
  int       err_cnt = 0;
  int       gap_cnt = 0;
  int       quiet_cnt = 0;
  bit       fill_done = 1'b0;

  fermi_dirac_charge_density_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .potential_i    (potential_i),
    .test_value_i   (test_value_i),
    .shape_value_i  (shape_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .residual_o     (residual_o),
    .jacobian_o     (jacobian_o),
    .saturated_o    (saturated_o)
  );

  // clock and reset
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // logistic lookup, e^(-16/depth) from a Taylor series in Q31
  function automatic void init_occ_lut();
    longint          term, acc, step;
    longint unsigned ratio, pw, den, one31;
    int              mid;
    one31 = 64'd1 << 31;
    term  = longint'(one31);
    acc   = longint'(one31);
    step  = (longint'(16) << 31) / TBL_DEPTH;
    mid   = TBL_DEPTH / 2;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * step) >>> 31) / k;
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    ratio = longint'(acc);
    pw    = one31;
    for (int k = 0; k <= mid; k++) begin
      den = one31 + pw;
      if (mid + k < TBL_DEPTH)
        occ_lut[mid + k] = (k == 0) ? longint'(((one31 << FRAC_BITS) + den / 2) / den)
                                    : longint'(((pw << FRAC_BITS) + den / 2) / den);
      if (mid - k >= 0)
        occ_lut[mid - k] = longint'(((one31 << FRAC_BITS) + den / 2) / den);
      pw = (pw * ratio + (one31 >> 1)) >> 31;
    end
  endfunction

  // truncating fixed point product with the magnitude cap of the chain
  function automatic longint fx_prod(longint a, longint b);
    logic [127:0]    wide;
    longint unsigned ua, ub, mag;
    ua   = (a < 0) ? longint'(-a) : longint'(a);
    ub   = (b < 0) ? longint'(-b) : longint'(b);
    wide = {64'd0, ua} * {64'd0, ub};
    wide = wide >> FRAC_BITS;
    mag  = (wide > {64'd0, CHAIN_LIM}) ? CHAIN_LIM : wide[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp32(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // occupation of one level at the given potential
  function automatic longint level_occ(longint offset, longint pot);
    longint          d, x, span, t, idx;
    longint unsigned md, xm;
    d  = offset - pot;
    md = (d < 0) ? longint'(-d) : longint'(d);
    xm = (longint'(reg_mirror[REG_Q_OVER_KT]) * md) >> FRAC_BITS;
    if (xm > X_CAP) xm = X_CAP;
    x    = (d < 0) ? -longint'(xm) : longint'(xm);
    span = longint'(16) << FRAC_BITS;
    t    = x * TBL_DEPTH + longint'(TBL_DEPTH / 2) * span + span / 2;
    idx  = (t < 0) ? 0 : t / span;
    if (idx > TBL_DEPTH - 1) idx = TBL_DEPTH - 1;
    return occ_lut[idx];
  endfunction

  function automatic density_t predict_density(cmd_t c);
    density_t r;
    longint   fa, fc, fv, s, rho, g, jac, na, nc, nv, q;
    bit       flag;
    flag = 1'b0;
    na   = reg_mirror[REG_ACC_DENS];
    nc   = reg_mirror[REG_COND_DENS];
    nv   = reg_mirror[REG_VAL_DENS];
    q    = reg_mirror[REG_CHARGE_Q];
    fa   = level_occ(reg_mirror[REG_ACC_OFFSET], c.pot);
    fc   = level_occ(reg_mirror[REG_COND_OFFSET], c.pot);
    fv   = level_occ(reg_mirror[REG_VAL_OFFSET], c.pot);
    s    = fx_prod(nv, ONE_Q - fv) - fx_prod(nc, fc) - fx_prod(na, fa);
    rho  = fx_prod(q, s);
    r.residual = 32'(clamp32(fx_prod(rho, c.test), flag));
    g    = fx_prod(na, fx_prod(fa, ONE_Q - fa)) + fx_prod(nc, fx_prod(fc, ONE_Q - fc))
         + fx_prod(nv, fx_prod(fv, ONE_Q - fv));
    jac  = fx_prod(q, reg_mirror[REG_Q_OVER_KT]);
    jac  = fx_prod(jac, g);
    jac  = fx_prod(jac, c.test);
    jac  = fx_prod(jac, c.shape);
    r.jacobian = 32'(clamp32(-jac, flag));
    r.sat = flag;
    return r;
  endfunction

  function automatic void mirror_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      REG_CHARGE_Q, REG_ACC_OFFSET, REG_COND_OFFSET, REG_VAL_OFFSET:
        reg_mirror[idx] = longint'(signed'(data));
      REG_Q_OVER_KT, REG_ACC_DENS, REG_COND_DENS, REG_VAL_DENS:
        reg_mirror[idx] = longint'({1'b0, data[30:0]});
      default: ;
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_point(logic [31:0] p, logic [31:0] t, logic [31:0] s, bit burst);
    cmd_t c;
    c = '{CMD_POINT, '0, '0, p, t, s, pick_gap(burst)};
    cmd_q.push_back(c);
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cmd_t c;
    c = '{CMD_WRITE, idx, data, '0, '0, '0, 0};
    cmd_q.push_back(c);
  endfunction

  function automatic void add_drain();
    cmd_t c;
    c = '{CMD_DRAIN, '0, '0, '0, '0, '0, 0};
    cmd_q.push_back(c);
  endfunction

  // full register set after a drain mark, plus a write to an unused index
  function automatic void add_reg_set(logic [31:0] q, logic [31:0] qkt, logic [31:0] na,
                                      logic [31:0] nc, logic [31:0] nv, logic [31:0] oa,
                                      logic [31:0] oc, logic [31:0] ov);
    add_drain();
    add_write(REG_CHARGE_Q, q);
    add_write(REG_Q_OVER_KT, qkt);
    add_write(REG_ACC_DENS, na);
    add_write(REG_COND_DENS, nc);
    add_write(REG_VAL_DENS, nv);
    add_write(REG_ACC_OFFSET, oa);
    add_write(REG_COND_OFFSET, oc);
    add_write(REG_VAL_OFFSET, ov);
    add_write(CFG_IDX_W'($urandom_range(8, 15)), $urandom);
  endfunction

  function automatic logic [31:0] rand_field(int mode);
    case (mode)
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
      2:       return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic void add_random_phase(int n);
    bit burst;
    burst = 1'b0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      add_point(rand_field($urandom_range(0, 9) < 3 ? 0 : 1),
                rand_field($urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 9) < 8 ? 2 : 3)),
                rand_field($urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 9) < 8 ? 2 : 3)),
                burst);
    end
  endfunction

  // command queue
  initial begin
    logic [31:0] ext[6];
    ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h1};
    init_occ_lut();
    reg_mirror = '{ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0};

    // directed: field extremes under reset values
    foreach (ext[i]) add_point(ext[i], 32'h0001_0000, 32'h0001_0000, 1'b0);
    add_point(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_point(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    add_point(32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    add_point(32'h0, 32'h0, 32'h0, 1'b0);
    // nearest entry with halves rounding up, either side of zero
    add_point(32'h0000_0800, 32'h0001_0000, 32'h0001_0000, 1'b1);
    add_point(-32'sd2048, 32'h0001_0000, 32'h0001_0000, 1'b1);
    add_point(-32'sd10240, 32'h0001_0000, 32'h0001_0000, 1'b1);
    add_point(32'sd10240 - 32'sd4096, 32'h0001_0000, 32'h0001_0000, 1'b1);
    // beyond the table on both sides
    add_point(32'h0009_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
    add_point(32'hFFF7_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);

    // argument cap and large products
    add_reg_set(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    foreach (ext[i]) add_point(ext[i], ext[(i + 1) % 6], ext[(i + 2) % 6], 1'b0);

    // opposite extremes, unsigned registers at zero
    add_reg_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    foreach (ext[i]) add_point(ext[i], ext[(i + 3) % 6], ext[(i + 4) % 6], 1'b0);

    add_random_phase(100);

    // random register sets, physical-ish ranges mostly
    for (int ph = 0; ph < 8; ph++) begin
      add_reg_set(ph == 0 ? $urandom : rand_field(1),
                  ph == 1 ? $urandom : $urandom_range(32'h0000_1000, 32'h0028_0000),
                  ph == 2 ? $urandom : $urandom_range(0, 32'h0100_0000),
                  ph == 3 ? $urandom : $urandom_range(0, 32'h0100_0000),
                  ph == 4 ? $urandom : $urandom_range(0, 32'h0100_0000),
                  ph == 5 ? $urandom : rand_field(1),
                  ph == 6 ? $urandom : rand_field(1),
                  ph == 7 ? $urandom : rand_field(1));
      add_random_phase(125);
    end
    fill_done = 1'b1;
  end

  // driver: one command per decision, points held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      start    <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      if (start && !busy) density_q.push_back(predict_density(
          '{CMD_POINT, '0, '0, potential_i, test_value_i, shape_value_i, 0}));
      if (density_q.size() == 0 && !start) quiet_cnt++;
      else quiet_cnt = 0;
      if (!(start && busy)) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          start    <= 1'b0;
          cfg_we_i <= 1'b0;
        end else if (cmd_q.size() == 0) begin
          start    <= 1'b0;
          cfg_we_i <= 1'b0;
        end else begin
          c = cmd_q[0];
          case (c.kind)
            CMD_POINT: begin
              start         <= 1'b1;
              cfg_we_i      <= 1'b0;
              potential_i   <= c.pot;
              test_value_i  <= c.test;
              shape_value_i <= c.shape;
              gap_cnt = c.gap;
              void'(cmd_q.pop_front());
            end
            CMD_WRITE: begin
              start      <= 1'b0;
              cfg_we_i   <= 1'b1;
              cfg_idx_i  <= c.idx;
              cfg_data_i <= c.data;
              mirror_write(c.idx, c.data);
              void'(cmd_q.pop_front());
            end
            default: begin
              start    <= 1'b0;
              cfg_we_i <= 1'b0;
              if (quiet_cnt >= SETTLE) void'(cmd_q.pop_front());
            end
          endcase
        end
      end
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch %s got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // monitor: every result beat against the oldest prediction
  always @(posedge clk_i) begin
    density_t w;
    if (rst_ni && result_valid_o) begin
      if (density_q.size() == 0) begin
        report_mismatch("unexpected beat residual", residual_o, '0);
      end else begin
        w = density_q.pop_front();
        if (residual_o !== w.residual) report_mismatch("residual", residual_o, w.residual);
        if (jacobian_o !== w.jacobian) report_mismatch("jacobian", jacobian_o, w.jacobian);
        if (saturated_o !== w.sat) report_mismatch("saturated", 32'(saturated_o), 32'(w.sat));
      end
    end
  end

  // end of run
  initial begin
    wait (fill_done);
    while (cmd_q.size() != 0 || start || density_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (density_q.size() != 0) begin
      $display("tb: %0d results never arrived", density_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule
